/* rtl/fhhl_pkg.sv */
// Shared types, codes and helpers for the floating-horizon hidden-line core.
// No dependencies.
package fhhl_pkg;

    localparam int HGT_W   = 32;
    localparam int IDX_W   = 17;   // signed column index / touched range
    localparam int COL_W   = 14;   // unsigned column compare width
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 66;
    localparam int DVD_W   = 67;
    localparam int DVS_W   = 33;
    localparam int Q_W     = 68;
    localparam int WIDE_W  = 70;
    localparam int NREG    = 8;
    localparam int CFG_IDX_W = 4;

    typedef logic [1:0] flag_t;
    localparam flag_t FLAG_OLD   = 2'd0;
    localparam flag_t FLAG_NEW   = 2'd1;
    localparam flag_t FLAG_NEVER = 2'd2;

    typedef logic [2:0] mode_t;
    localparam mode_t MODE_CLEAR  = 3'd0;
    localparam mode_t MODE_START  = 3'd1;
    localparam mode_t MODE_DRAW   = 3'd2;
    localparam mode_t MODE_READ   = 3'd3;
    localparam mode_t MODE_COMMIT = 3'd4;

    localparam int REG_CXX = 0;
    localparam int REG_CXY = 1;
    localparam int REG_CXZ = 2;
    localparam int REG_CYX = 3;
    localparam int REG_CYY = 4;
    localparam int REG_CYZ = 5;
    localparam int REG_OFX = 6;
    localparam int REG_OFY = 7;

    typedef struct packed {
        flag_t                    flag;
        logic signed [HGT_W-1:0]  height;
    } hz_entry_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [HGT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-HGT_W:0] top;
        top = v[WIDE_W-1:HGT_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[HGT_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

/* rtl/fhhl_mul.sv */
// Registered signed multiplier shared by projection and slope setup.
// Depends on fhhl_pkg.
module fhhl_mul
    import fhhl_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/fhhl_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on fhhl_pkg.
module fhhl_div
    import fhhl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot,
    output logic [DVS_W-1:0] rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DVD_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (cnt_reg != '0) begin
            if (!diff[DVS_W+1]) begin
                rem_reg <= diff[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/floating_horizon_hidden_line_core.sv */
// Floating-horizon hidden-line core: projection, horizon store, raster walk.
// A draw walks each spanned column, a commit each column in range, and a clear the whole store.
// One item at a time.
// The two 67-step slope divisions run one after the other on the shared divider.
// Reset: synchronous active-low; a clearing pass walks every column of the horizon
// store before the first beat is taken. Depends on fhhl_pkg, fhhl_mul, fhhl_div.
module floating_horizon_hidden_line_core
    import fhhl_pkg::*;
#(
    parameter int COLUMNS = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    // input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_mode,
    input  logic signed [31:0]    s_point_x,
    input  logic signed [31:0]    s_point_y,
    input  logic signed [31:0]    s_point_z,
    input  logic [10:0]           s_column,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_proj_col,
    output logic signed [31:0]    m_proj_height,
    output logic signed [31:0]    m_horizon_height,
    output logic                  m_pen_down,
    output logic [1:0]            m_column_state,
    output logic [11:0]           m_range_low,
    output logic [10:0]           m_range_high
);

    localparam int AW = $clog2(COLUMNS);
    localparam logic signed [IDX_W-1:0] COL_S  = IDX_W'(COLUMNS);
    localparam logic signed [IDX_W-1:0] COL_M2 = IDX_W'(COLUMNS - 2);
    localparam logic signed [IDX_W-1:0] COL_M1 = IDX_W'(COLUMNS - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_PROJ  = 4'd2;
    localparam logic [3:0] ST_PFIN  = 4'd3;
    localparam logic [3:0] ST_DSET  = 4'd4;
    localparam logic [3:0] ST_TMUL  = 4'd5;
    localparam logic [3:0] ST_TDIV  = 4'd6;
    localparam logic [3:0] ST_DIV1  = 4'd7;
    localparam logic [3:0] ST_DIV2  = 4'd8;
    localparam logic [3:0] ST_WALK  = 4'd9;
    localparam logic [3:0] ST_DRAIN = 4'd10;
    localparam logic [3:0] ST_CMT   = 4'd11;
    localparam logic [3:0] ST_RDA   = 4'd12;
    localparam logic [3:0] ST_RDB   = 4'd13;
    localparam logic [3:0] ST_RDC   = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    // ---------------- control state ----------------
    logic [3:0]              state_reg;
    logic                    boot_reg;
    logic [2:0]              step_reg;
    logic signed [IDX_W-1:0] n_reg;        // sweep / commit column
    logic signed [IDX_W-1:0] tl_reg;       // touched low
    logic signed [IDX_W-1:0] th_reg;       // touched high
    logic                    pv_reg;       // write stage valid
    logic                    pcmt_reg;     // write stage is a commit
    logic                    mvalid_reg;

    // ---------------- item / datapath ----------------
    logic signed [31:0]      coef_reg [NREG];
    mode_t                   mode_reg;
    logic signed [31:0]      px_reg, py_reg, pz_reg;
    logic [AW-1:0]           c_reg;
    flag_t                   prev_reg;
    logic signed [31:0]      pen_col_reg, pen_h_reg;
    logic signed [PROD_W-1:0] acc_x_reg, acc_y_reg;
    logic signed [31:0]      proj_col_reg, proj_h_reg, hh_reg;
    logic                    pd_reg;
    flag_t                   cs_reg;
    // slope walk
    logic [AW-1:0]           col_reg, hi_reg;
    logic signed [MUL_W-1:0] dy_reg, t0_reg;
    logic                    sgn_reg, neg0_reg, sneg_reg;
    logic [DVS_W-1:0]        d_reg;
    logic signed [Q_W-1:0]   q_reg, qs_reg;
    logic [DVS_W-1:0]        r_reg, rs_reg;
    logic [AW-1:0]           pcol_reg;
    logic signed [31:0]      hp_reg;
    // output beat
    logic signed [31:0]      mo_pc_reg, mo_ph_reg, mo_hh_reg;
    logic                    mo_pd_reg;
    flag_t                   mo_cs_reg;
    logic [11:0]             mo_rl_reg;
    logic [10:0]             mo_rh_reg;

    // ---------------- horizon store ----------------
    logic [$bits(hz_entry_t)-1:0] mem [COLUMNS];
    hz_entry_t   rd_entry;
    logic [AW-1:0] raddr, waddr;
    logic        we;
    hz_entry_t   wdata;

    logic accept;
    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- shared multiplier ----------------
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    always_comb begin
        mul_a = dy_reg;
        mul_b = t0_reg;
        if (state_reg == ST_PROJ) begin
            case (step_reg)
                3'd0: begin mul_a = MUL_W'(coef_reg[REG_CXX]); mul_b = MUL_W'(px_reg); end
                3'd1: begin mul_a = MUL_W'(coef_reg[REG_CXY]); mul_b = MUL_W'(py_reg); end
                3'd2: begin mul_a = MUL_W'(coef_reg[REG_CXZ]); mul_b = MUL_W'(pz_reg); end
                3'd3: begin mul_a = MUL_W'(coef_reg[REG_CYX]); mul_b = MUL_W'(px_reg); end
                3'd4: begin mul_a = MUL_W'(coef_reg[REG_CYY]); mul_b = MUL_W'(py_reg); end
                3'd5: begin mul_a = MUL_W'(coef_reg[REG_CYZ]); mul_b = MUL_W'(pz_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    fhhl_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---------------- projection finish ----------------
    logic signed [WIDE_W-1:0] pc_wide, ph_wide;
    assign pc_wide = WIDE_W'(acc_x_reg >>> 16) + WIDE_W'(coef_reg[REG_OFX]);
    assign ph_wide = WIDE_W'(acc_y_reg >>> 16) + WIDE_W'(coef_reg[REG_OFY]);

    // ---------------- draw setup: widen and slope inputs ----------------
    logic signed [IDX_W-1:0] in_idx, il_idx, tl_a, th_a, tl_b, th_b;
    logic                    in_ok, il_ok, walk;
    logic signed [31:0]      xmin, xmax;
    logic signed [MUL_W-1:0] lo_full, dx, dy;
    logic [AW-1:0]           lo_col;

    assign in_idx = IDX_W'(proj_col_reg >>> 16);
    assign il_idx = IDX_W'(pen_col_reg >>> 16);
    assign in_ok  = (in_idx >= 0) && (in_idx < COL_M2);
    assign il_ok  = (il_idx >= 0) && (il_idx < COL_M2);
    assign walk   = in_ok && il_ok && (in_idx != il_idx);
    assign tl_a   = (in_idx < tl_reg) ? in_idx : tl_reg;
    assign th_a   = (in_idx > th_reg) ? in_idx : th_reg;
    assign tl_b   = (in_ok && (il_idx < tl_a)) ? il_idx : tl_a;
    assign th_b   = (in_ok && (il_idx > th_a)) ? il_idx : th_a;

    assign xmin    = (proj_col_reg < pen_col_reg) ? proj_col_reg : pen_col_reg;
    assign xmax    = (proj_col_reg < pen_col_reg) ? pen_col_reg : proj_col_reg;
    assign lo_full = (MUL_W'(xmin) + 33'sd65535) >>> 16;
    assign lo_col  = lo_full[AW-1:0];
    assign dx      = MUL_W'(proj_col_reg) - MUL_W'(pen_col_reg);
    assign dy      = MUL_W'(proj_h_reg) - MUL_W'(pen_h_reg);

    // ---------------- divider and floor conversion ----------------
    logic                    div_start, div_done;
    logic [DVD_W-1:0]        div_dvd, div_q;
    logic [DVS_W-1:0]        div_r;
    logic signed [DVD_W-1:0] n0, s_num;
    logic                    conv_neg;
    logic signed [Q_W-1:0]   conv_q;
    logic [DVS_W-1:0]        conv_r;

    assign n0    = sgn_reg ? -DVD_W'(prod) : DVD_W'(prod);
    assign s_num = sgn_reg ? -DVD_W'($signed({dy_reg, 16'h0000}))
                           : DVD_W'($signed({dy_reg, 16'h0000}));

    always_comb begin
        div_start = 1'b0;
        div_dvd   = n0[DVD_W-1] ? DVD_W'(-n0) : DVD_W'(n0);
        if (state_reg == ST_TDIV) begin
            div_start = 1'b1;
        end else if (state_reg == ST_DIV1 && div_done) begin
            div_start = 1'b1;
            div_dvd   = s_num[DVD_W-1] ? DVD_W'(-s_num) : DVD_W'(s_num);
        end
    end

    fhhl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (d_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // magnitude quotient -> floor quotient with remainder in [0, D)
    assign conv_neg = (state_reg == ST_DIV1) ? neg0_reg : sneg_reg;
    always_comb begin
        if (!conv_neg) begin
            conv_q = Q_W'(div_q);
            conv_r = div_r;
        end else if (div_r == '0) begin
            conv_q = -Q_W'(div_q);
            conv_r = '0;
        end else begin
            conv_q = -Q_W'(div_q) - Q_W'(1);
            conv_r = d_reg - div_r;
        end
    end

    // ---------------- column walk step ----------------
    logic signed [Q_W-1:0]    trunc_q, q_next;
    logic [DVS_W:0]           r_sum;
    logic                     r_ge;
    logic [DVS_W-1:0]         r_next;
    logic signed [WIDE_W-1:0] h_wide;

    assign trunc_q = q_reg + Q_W'((q_reg < 0) && (r_reg != '0));
    assign h_wide  = WIDE_W'(pen_h_reg) + WIDE_W'(trunc_q);
    assign r_sum   = {1'b0, r_reg} + {1'b0, rs_reg};
    assign r_ge    = (r_sum >= {1'b0, d_reg});
    assign r_next  = r_ge ? DVS_W'(r_sum - {1'b0, d_reg}) : r_sum[DVS_W-1:0];
    assign q_next  = q_reg + qs_reg + Q_W'(r_ge);

    // ---------------- store ports ----------------
    always_comb begin
        unique case (state_reg)
            ST_RDA:  raddr = c_reg - 1'b1;
            ST_WALK: raddr = col_reg;
            ST_CMT:  raddr = n_reg[AW-1:0];
            default: raddr = c_reg;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = pcol_reg;
        wdata = '{flag: FLAG_NEW, height: hp_reg};
        if (state_reg == ST_CLR) begin
            we    = 1'b1;
            waddr = n_reg[AW-1:0];
            wdata = '{flag: FLAG_NEVER, height: '0};
        end else if (pv_reg) begin
            if (pcmt_reg) begin
                we    = (rd_entry.flag == FLAG_NEW);
                wdata = '{flag: FLAG_OLD, height: rd_entry.height};
            end else begin
                we = (hp_reg >= rd_entry.height);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_entry <= mem[raddr];
    end

    // ---------------- range clip ----------------
    logic signed [IDX_W-1:0] clip_low, clip_high;
    assign clip_low  = (tl_reg < IDX_W'(1)) ? IDX_W'(1) : tl_reg;
    assign clip_high = (th_reg > COL_M2) ? COL_M2 : th_reg;

    // read pen decision
    logic pd_calc;
    always_comb begin
        case (rd_entry.flag)
            FLAG_NEW: pd_calc = (prev_reg != FLAG_NEVER);
            FLAG_OLD: pd_calc = (prev_reg == FLAG_NEW);
            default:  pd_calc = 1'b0;
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NREG; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NREG))) begin
            coef_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            boot_reg    <= 1'b1;
            n_reg       <= '0;
            step_reg    <= '0;
            tl_reg      <= COL_S;
            th_reg      <= '0;
            pen_col_reg <= '0;
            pen_h_reg   <= '0;
            pv_reg      <= 1'b0;
            pcmt_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
        end else begin
            pv_reg <= 1'b0;
            if (mvalid_reg && m_ready) begin
                mvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mode_reg     <= s_mode;
                        px_reg       <= s_point_x;
                        py_reg       <= s_point_y;
                        pz_reg       <= s_point_z;
                        proj_col_reg <= '0;
                        proj_h_reg   <= '0;
                        hh_reg       <= '0;
                        pd_reg       <= 1'b0;
                        cs_reg       <= FLAG_OLD;
                        acc_x_reg    <= '0;
                        acc_y_reg    <= '0;
                        step_reg     <= '0;
                        prev_reg     <= FLAG_NEVER;
                        c_reg        <= AW'(s_column);
                        case (s_mode)
                            MODE_CLEAR: begin
                                n_reg     <= '0;
                                state_reg <= ST_CLR;
                            end
                            MODE_START, MODE_DRAW: begin
                                state_reg <= ST_PROJ;
                            end
                            MODE_READ: begin
                                if (COL_W'(s_column) >= COL_W'(COLUMNS)) begin
                                    cs_reg    <= FLAG_NEVER;
                                    state_reg <= ST_OUT;
                                end else if (s_column == '0) begin
                                    state_reg <= ST_RDB;
                                end else begin
                                    state_reg <= ST_RDA;
                                end
                            end
                            MODE_COMMIT: begin
                                tl_reg    <= clip_low;
                                th_reg    <= clip_high;
                                n_reg     <= clip_low;
                                state_reg <= ST_CMT;
                            end
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_CLR: begin
                    n_reg <= n_reg + 1'b1;
                    if (n_reg == COL_M1) begin
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_OUT;
                    end
                end
                ST_PROJ: begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg != 3'd0) begin
                        if (step_reg <= 3'd3) begin
                            acc_x_reg <= acc_x_reg + prod;
                        end else begin
                            acc_y_reg <= acc_y_reg + prod;
                        end
                    end
                    if (step_reg == 3'd6) begin
                        state_reg <= ST_PFIN;
                    end
                end
                ST_PFIN: begin
                    proj_col_reg <= sat32(pc_wide);
                    proj_h_reg   <= sat32(ph_wide);
                    state_reg    <= ST_DSET;
                end
                ST_DSET: begin
                    if (mode_reg == MODE_START) begin
                        tl_reg      <= COL_S;
                        th_reg      <= '0;
                        pen_col_reg <= proj_col_reg;
                        pen_h_reg   <= proj_h_reg;
                        state_reg   <= ST_OUT;
                    end else begin
                        tl_reg <= tl_b;
                        th_reg <= th_b;
                        if (walk) begin
                            col_reg   <= lo_col;
                            hi_reg    <= AW'(xmax >>> 16);
                            dy_reg    <= dy;
                            sgn_reg   <= dx[MUL_W-1];
                            d_reg     <= dx[MUL_W-1] ? DVS_W'(-dx) : DVS_W'(dx);
                            t0_reg    <= $signed(MUL_W'({lo_col, 16'h0000}))
                                         - MUL_W'(pen_col_reg);
                            state_reg <= ST_TMUL;
                        end else begin
                            pen_col_reg <= proj_col_reg;
                            pen_h_reg   <= proj_h_reg;
                            state_reg   <= ST_OUT;
                        end
                    end
                end
                ST_TMUL: begin
                    state_reg <= ST_TDIV;
                end
                ST_TDIV: begin
                    neg0_reg  <= n0[DVD_W-1];
                    state_reg <= ST_DIV1;
                end
                ST_DIV1: begin
                    if (div_done) begin
                        q_reg     <= conv_q;
                        r_reg     <= conv_r;
                        sneg_reg  <= s_num[DVD_W-1];
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        qs_reg    <= conv_q;
                        rs_reg    <= conv_r;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    pv_reg   <= 1'b1;
                    pcmt_reg <= 1'b0;
                    pcol_reg <= col_reg;
                    hp_reg   <= sat32(h_wide);
                    q_reg    <= q_next;
                    r_reg    <= r_next;
                    col_reg  <= col_reg + 1'b1;
                    if (col_reg == hi_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    pen_col_reg <= proj_col_reg;
                    pen_h_reg   <= proj_h_reg;
                    state_reg   <= ST_OUT;
                end
                ST_CMT: begin
                    if (n_reg > th_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        pv_reg   <= 1'b1;
                        pcmt_reg <= 1'b1;
                        pcol_reg <= n_reg[AW-1:0];
                        n_reg    <= n_reg + 1'b1;
                    end
                end
                ST_RDA: begin
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    if (c_reg != '0) begin
                        prev_reg <= rd_entry.flag;
                    end
                    state_reg <= ST_RDC;
                end
                ST_RDC: begin
                    hh_reg    <= rd_entry.height;
                    cs_reg    <= rd_entry.flag;
                    pd_reg    <= pd_calc;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!mvalid_reg || m_ready) begin
                        mvalid_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!mvalid_reg || m_ready)) begin
            mo_pc_reg <= proj_col_reg;
            mo_ph_reg <= proj_h_reg;
            mo_hh_reg <= hh_reg;
            mo_pd_reg <= pd_reg;
            mo_cs_reg <= cs_reg;
            mo_rl_reg <= clip_low[11:0];
            mo_rh_reg <= clip_high[10:0];
        end
    end

    assign m_valid          = mvalid_reg;
    assign m_proj_col       = mo_pc_reg;
    assign m_proj_height    = mo_ph_reg;
    assign m_horizon_height = mo_hh_reg;
    assign m_pen_down       = mo_pd_reg;
    assign m_column_state   = mo_cs_reg;
    assign m_range_low      = mo_rl_reg;
    assign m_range_high     = mo_rh_reg;

endmodule

/* test/tb_floating_horizon_hidden_line_core.sv */
// Self-checking bench for floating_horizon_hidden_line_core: projection, horizon raise,
// commit, read and clear checked beat by beat against an in-bench horizon predictor.
// Depends on fhhl_pkg and the core RTL only.
module tb_floating_horizon_hidden_line_core;
    import fhhl_pkg::*;

    localparam int  NCOL     = 2048;
    localparam int  ONE      = 65536;          // 1.0 in Q16.16
    localparam int  SAT_HI   = 32'sh7FFF_FFFF;
    localparam int  SAT_LO   = 32'sh8000_0000;

    typedef logic [31:0] cfg_set_t [NREG];

    // one expected result beat
    typedef struct {
        logic signed [31:0] proj_col;
        logic signed [31:0] proj_height;
        logic signed [31:0] horizon_height;
        logic               pen_down;
        logic [1:0]         column_state;
        logic [11:0]        range_low;
        logic [10:0]        range_high;
    } horizon_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_mode = MODE_READ;
    logic signed [31:0]   s_point_x = '0;
    logic signed [31:0]   s_point_y = '0;
    logic signed [31:0]   s_point_z = '0;
    logic [10:0]          s_column = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_proj_col;
    logic signed [31:0]   m_proj_height;
    logic signed [31:0]   m_horizon_height;
    logic                 m_pen_down;
    logic [1:0]           m_column_state;
    logic [11:0]          m_range_low;
    logic [10:0]          m_range_high;

    floating_horizon_hidden_line_core #(.COLUMNS(NCOL)) uut (.*);

    // ---------------- predictor state ----------------
    logic signed [31:0] weight [NREG];
    logic signed [31:0] hz_height [NCOL];
    flag_t              hz_flag [NCOL];
    longint             pen_col, pen_height;
    longint             touched_low, touched_high;

    horizon_beat_t pending_beats[$];
    int            mismatches = 0;
    bit            quiet = 1'b0;     // no idling on either side while set

    initial forever #5 aclk = ~aclk;

    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) return SAT_HI;
        if (v < -70'sd2147483648) return SAT_LO;
        return v[31:0];
    endfunction

    // exact three-term sum, floor by 2^16, then offset and saturate
    function automatic logic signed [31:0] weigh_point(input int base, input int off_reg,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        logic signed [69:0] acc;
        acc = 70'(longint'(weight[base]) * longint'(px))
            + 70'(longint'(weight[base+1]) * longint'(py))
            + 70'(longint'(weight[base+2]) * longint'(pz));
        acc = (acc >>> 16) + 70'(weight[off_reg]);
        return clamp32(acc);
    endfunction

    function automatic void widen_range(input longint idx);
        if (idx > touched_high) touched_high = idx;
        if (idx < touched_low) touched_low = idx;
    endfunction

    function automatic longint clip_low();
        return touched_low < 1 ? 1 : touched_low;
    endfunction

    function automatic longint clip_high();
        return touched_high > NCOL - 2 ? NCOL - 2 : touched_high;
    endfunction

    // raster walk from the pen to (x2,y2), raising the horizon where on or above it
    function automatic void raise_segment(input longint x2, input longint y2);
        longint xp, yp, in_i, il, xmin, xmax, lo, hi, dx, dy, t, h;
        xp = pen_col;
        yp = pen_height;
        in_i = x2 >>> 16;
        il = xp >>> 16;
        widen_range(in_i);
        if (in_i >= 0 && in_i < NCOL - 2) begin
            widen_range(il);
            if (il >= 0 && il < NCOL - 2 && in_i != il) begin
                xmin = x2 < xp ? x2 : xp;
                xmax = x2 < xp ? xp : x2;
                lo = (xmin + 65535) >>> 16;
                hi = xmax >>> 16;
                dx = x2 - xp;
                dy = y2 - yp;
                for (longint i = lo; i <= hi; i++) begin
                    t = i * 65536 - xp;
                    h = clamp32(70'(yp + (dy * t) / dx));
                    if (i >= 0 && i < NCOL && h >= longint'(hz_height[i])) begin
                        hz_height[i] = h[31:0];
                        hz_flag[i] = FLAG_NEW;
                    end
                end
            end
        end
        pen_col = x2;
        pen_height = y2;
    endfunction

    function automatic horizon_beat_t step_horizon(input logic [2:0] mode,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz, input logic [10:0] col);
        horizon_beat_t r;
        flag_t f, left;
        r = '{default: '0};
        case (mode)
            MODE_CLEAR: begin
                for (int n = 0; n < NCOL; n++) begin
                    hz_height[n] = '0;
                    hz_flag[n] = FLAG_NEVER;
                end
            end
            MODE_START, MODE_DRAW: begin
                r.proj_col = weigh_point(REG_CXX, REG_OFX, px, py, pz);
                r.proj_height = weigh_point(REG_CYX, REG_OFY, px, py, pz);
                if (mode == MODE_START) begin
                    touched_low = NCOL;
                    touched_high = 0;
                    pen_col = r.proj_col;
                    pen_height = r.proj_height;
                end else begin
                    raise_segment(r.proj_col, r.proj_height);
                end
            end
            MODE_READ: begin
                f = hz_flag[col];
                left = (col == 0) ? FLAG_NEVER : hz_flag[col-1];
                r.horizon_height = hz_height[col];
                r.column_state = f;
                if (f == FLAG_NEW) r.pen_down = (left != FLAG_NEVER);
                else if (f == FLAG_OLD) r.pen_down = (left == FLAG_NEW);
            end
            MODE_COMMIT: begin
                touched_low = clip_low();
                touched_high = clip_high();
                for (longint n = touched_low; n <= touched_high; n++)
                    if (n >= 0 && n < NCOL && hz_flag[n] == FLAG_NEW) hz_flag[n] = FLAG_OLD;
            end
            default: ;  // unused modes leave everything alone
        endcase
        r.range_low = 12'(clip_low());
        r.range_high = 11'(clip_high());
        return r;
    endfunction

    // ---------------- result side: stall and compare ----------------
    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] %s: got %0d, want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        horizon_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                want = pending_beats.pop_front();
                if (m_proj_col !== want.proj_col)
                    report_mismatch("proj_col", m_proj_col, want.proj_col);
                if (m_proj_height !== want.proj_height)
                    report_mismatch("proj_height", m_proj_height, want.proj_height);
                if (m_horizon_height !== want.horizon_height)
                    report_mismatch("horizon_height", m_horizon_height, want.horizon_height);
                if (m_pen_down !== want.pen_down)
                    report_mismatch("pen_down", m_pen_down, want.pen_down);
                if (m_column_state !== want.column_state)
                    report_mismatch("column_state", m_column_state, want.column_state);
                if (m_range_low !== want.range_low)
                    report_mismatch("range_low", m_range_low, want.range_low);
                if (m_range_high !== want.range_high)
                    report_mismatch("range_high", m_range_high, want.range_high);
            end
        end
        m_ready <= quiet || ($urandom_range(99) >= 26);
    end

    // ---------------- input side ----------------
    // Valid stays up into the next beat unless a random gap is taken.
    task automatic send_item(input logic [2:0] mode, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz,
            input logic [10:0] col);
        s_mode <= mode;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        s_column <= col;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_beats.push_back(step_horizon(mode, px, py, pz, col));
        if (!quiet && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain();
        s_valid <= 1'b0;
        wait (pending_beats.size() == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_config(input cfg_set_t vals);
        drain();
        for (int i = 0; i < NREG; i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            weight[i] = vals[i];
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Q16.16 coordinate at a column with a random fraction
    function automatic logic signed [31:0] at_column(input int c);
        return (c <<< 16) + $urandom_range(ONE - 1);
    endfunction

    function automatic logic signed [31:0] any_height();
        return ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(ONE * 400)) - ONE * 200;
    endfunction

    // well-formed polylines with commits and reads, plus noise beats
    task automatic random_polylines(input int n_items);
        int sent, c, steps;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                c = $urandom_range(1, NCOL - 10);
                send_item(MODE_START, at_column(c), any_height(), $urandom, $urandom);
                steps = $urandom_range(2, 8);
                for (int k = 0; k < steps; k++) begin
                    c = c + $signed($urandom_range(80)) - 40;
                    if ($urandom_range(19) == 0) c = $urandom_range(NCOL + 20) - 10;
                    send_item(MODE_DRAW, at_column(c), any_height(), $urandom, $urandom);
                end
                sent += steps + 1;
                if ($urandom_range(9) < 7) begin
                    send_item(MODE_COMMIT, $urandom, $urandom, $urandom, $urandom);
                    sent++;
                end
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    send_item(MODE_READ, $urandom, $urandom, $urandom,
                              11'(c + $signed($urandom_range(40)) - 20));
                    sent++;
                end
            end else begin
                c = $urandom_range(7);
                // a clear costs a full pass over the store, keep it rare
                if (c == MODE_CLEAR && $urandom_range(3) != 0) c = MODE_READ;
                send_item(3'(c), $urandom, $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_saturation();
        cfg_set_t hi_set, lo_set;
        hi_set = '{default: SAT_HI};
        lo_set = '{default: SAT_LO};
        load_config(hi_set);
        send_item(MODE_START, SAT_HI, SAT_HI, SAT_HI, 11'd0);
        send_item(MODE_DRAW, SAT_LO, SAT_LO, SAT_LO, 11'd0);
        send_item(MODE_DRAW, 32'sd0, 32'sd0, 32'sd0, 11'h7FF);
        send_item(MODE_COMMIT, SAT_LO, 32'sd1, -32'sd1, 11'h7FF);
        load_config(lo_set);
        send_item(MODE_START, SAT_LO, SAT_LO, SAT_LO, 11'd0);
        send_item(MODE_DRAW, SAT_HI, SAT_LO, SAT_HI, 11'd0);
        send_item(MODE_READ, 32'sd0, 32'sd0, 32'sd0, 11'h7FF);
        drain();
    endtask

    task automatic test_directed_walk();
        cfg_set_t ident;
        ident = '{default: '0};
        ident[REG_CXX] = ONE;
        ident[REG_CYY] = ONE;
        load_config(ident);
        send_item(MODE_START, 10 * ONE, 5 * ONE, 0, 0);
        send_item(MODE_DRAW, 20 * ONE + 100, 9 * ONE, 0, 0);      // raise 10..20
        send_item(MODE_DRAW, 14 * ONE, -3 * ONE, 0, 0);           // below, fully hidden
        send_item(MODE_DRAW, 14 * ONE + 999, 50 * ONE, 0, 0);     // same column: no raise
        send_item(MODE_DRAW, (NCOL - 2) * ONE, ONE, 0, 0);        // past the last walk column
        send_item(MODE_DRAW, -2 * ONE, ONE, 0, 0);                // negative column
        send_item(MODE_READ, 0, 0, 0, 11'd0);
        send_item(MODE_READ, 0, 0, 0, 11'd11);
        send_item(MODE_READ, 0, 0, 0, 11'd15);
        send_item(MODE_COMMIT, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 11'd10);
        send_item(MODE_READ, 0, 0, 0, 11'd20);
        send_item(MODE_READ, 0, 0, 0, 11'h7FF);
        send_item(3'd5, SAT_HI, SAT_LO, SAT_HI, 11'h7FF);
        send_item(3'd6, 0, 0, 0, 0);
        send_item(3'd7, 0, 0, 0, 0);
        send_item(MODE_CLEAR, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 11'd12);
        drain();
    endtask

    task automatic test_random_identity();
        cfg_set_t ident;
        ident = '{default: '0};
        ident[REG_CXX] = ONE;
        ident[REG_CYY] = ONE;
        ident[REG_OFY] = 3 * ONE;
        load_config(ident);
        random_polylines(450);
        drain();
    endtask

    task automatic test_random_quiet();
        quiet = 1'b1;     // long stretch with no gaps on either side
        random_polylines(250);
        drain();
        quiet = 1'b0;
    endtask

    task automatic test_random_mixed();
        cfg_set_t mixed;
        mixed[REG_CXX] = ONE;
        mixed[REG_CXY] = 32'h0000_0800;
        mixed[REG_CXZ] = -32'sh0000_0400;
        mixed[REG_CYX] = 32'h0000_1000;
        mixed[REG_CYY] = 32'h0001_6A0A;   // about root two
        mixed[REG_CYZ] = -ONE / 2;
        mixed[REG_OFX] = ONE / 2;
        mixed[REG_OFY] = -7 * ONE;
        load_config(mixed);
        random_polylines(400);
        drain();
    endtask

    initial begin
        // predictor starts from the post-reset store
        for (int n = 0; n < NCOL; n++) begin
            hz_height[n] = '0;
            hz_flag[n] = FLAG_NEVER;
        end
        pen_col = 0;
        pen_height = 0;
        touched_low = NCOL;
        touched_high = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_saturation();
        test_directed_walk();
        test_random_identity();
        test_random_quiet();
        test_random_mixed();
        repeat (300) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
